>>> hw/rtl/pqrl_pkg.sv
package pqrl_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 16;
    localparam int TIME_BITS   = 16;

    localparam int REQ_W      = 2;
    localparam int ID_FIELD_W = 16;
    localparam int TIME_FIELD_W = 16;
    localparam int STATUS_W   = 2;
    localparam int COUNT_FIELD_W = 5;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [REQ_W-1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEQUEUE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic shift_start;
        logic shift_step;
        logic finish;
    } pqrl_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_last;
        logic shift_done;
        logic out_free;
    } pqrl_sts_t;

endpackage

>>> hw/rtl/pqrl_req_if.sv
interface pqrl_req_if;

    logic                              valid;
    logic                              ready;
    logic [pqrl_pkg::REQ_W-1:0]        req_type;
    logic [pqrl_pkg::ID_FIELD_W-1:0]   proc_id;
    logic [pqrl_pkg::TIME_FIELD_W-1:0] run_time;

    modport source (output valid, output req_type, output proc_id, output run_time,
                    input ready);
    modport sink   (input valid, input req_type, input proc_id, input run_time,
                    output ready);

endinterface

>>> hw/rtl/pqrl_rsp_if.sv
interface pqrl_rsp_if;

    logic                               valid;
    logic                               ready;
    logic [pqrl_pkg::STATUS_W-1:0]      status;
    logic [pqrl_pkg::ID_FIELD_W-1:0]    out_id;
    logic [pqrl_pkg::COUNT_FIELD_W-1:0] entry_count;

    modport source (output valid, output status, output out_id, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input out_id, input entry_count,
                    output ready);

endinterface

>>> hw/rtl/pqrl_ctrl.sv
module pqrl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pqrl_pkg::pqrl_sts_t  sts,
    output pqrl_pkg::pqrl_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHECK    = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_SHIFT_RD = 3'd3;
    localparam logic [2:0] S_SHIFT    = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.need_scan)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD:
            begin
                cmd.shift_start = 1'b1;
                state_next      = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (sts.shift_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/pqrl_dpath.sv
module pqrl_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [pqrl_pkg::REQ_W-1:0]          req_type,
    input  logic [pqrl_pkg::ID_FIELD_W-1:0]     proc_id,
    input  logic [pqrl_pkg::TIME_FIELD_W-1:0]   run_time,
    input  pqrl_pkg::pqrl_cmd_t                 cmd,
    output pqrl_pkg::pqrl_sts_t                 sts,
    pqrl_rsp_if.source                          rsp
);

    logic [pqrl_pkg::ID_BITS-1:0]   ids_mem   [pqrl_pkg::QUEUE_DEPTH];
    logic [pqrl_pkg::TIME_BITS-1:0] times_mem [pqrl_pkg::QUEUE_DEPTH];

    logic [pqrl_pkg::CNT_W-1:0]         count_reg;
    logic [pqrl_pkg::CNT_W-1:0]         count_next;
    logic                               out_valid_reg;
    logic [pqrl_pkg::STATUS_W-1:0]      out_status_reg;
    logic [pqrl_pkg::STATUS_W-1:0]      out_status_next;
    logic [pqrl_pkg::ID_FIELD_W-1:0]    out_id_reg;
    logic [pqrl_pkg::ID_FIELD_W-1:0]    out_id_next;
    logic [pqrl_pkg::COUNT_FIELD_W-1:0] out_count_reg;

    logic [pqrl_pkg::REQ_W-1:0]     req_type_reg;
    logic [pqrl_pkg::ID_BITS-1:0]   id_in_reg;
    logic [pqrl_pkg::TIME_BITS-1:0] time_in_reg;
    logic [pqrl_pkg::CNT_W-1:0]     ptr_reg;
    logic [pqrl_pkg::CNT_W-1:0]     ptr_next;
    logic [pqrl_pkg::IDX_W-1:0]     best_idx_reg;
    logic [pqrl_pkg::TIME_BITS-1:0] best_time_reg;
    logic [pqrl_pkg::ID_BITS-1:0]   best_id_reg;
    logic [pqrl_pkg::ID_BITS-1:0]   rd_id_reg;
    logic [pqrl_pkg::TIME_BITS-1:0] rd_time_reg;

    logic                           is_remove;
    logic                           is_removal;
    logic                           full;
    logic                           empty;
    logic [pqrl_pkg::CNT_W-1:0]     scan_end;
    logic [pqrl_pkg::CNT_W-1:0]     eval_pos;
    logic [pqrl_pkg::CNT_W-1:0]     ptr_inc;
    logic [pqrl_pkg::CNT_W-1:0]     ptr_inc2;
    logic                           take_new;
    logic                           commit;
    logic [pqrl_pkg::IDX_W-1:0]     rd_addr;
    logic                           wr_en;
    logic [pqrl_pkg::IDX_W-1:0]     wr_addr;
    logic [pqrl_pkg::ID_BITS-1:0]   wr_id;
    logic [pqrl_pkg::TIME_BITS-1:0] wr_time;

    assign is_remove  = (req_type_reg == pqrl_pkg::REQ_REMOVE);
    assign is_removal = req_type_reg inside {pqrl_pkg::REQ_DEQUEUE, pqrl_pkg::REQ_REMOVE};
    assign full       = (count_reg == pqrl_pkg::CNT_W'(pqrl_pkg::QUEUE_DEPTH));
    assign empty      = (count_reg == '0);
    assign scan_end   = is_remove ? count_reg : pqrl_pkg::CNT_W'(1);
    assign eval_pos   = ptr_reg - pqrl_pkg::CNT_W'(1);
    assign ptr_inc    = ptr_reg + pqrl_pkg::CNT_W'(1);
    assign ptr_inc2   = ptr_reg + pqrl_pkg::CNT_W'(2);
    assign take_new   = (ptr_reg == pqrl_pkg::CNT_W'(1)) || (rd_time_reg > best_time_reg);

    assign sts.need_scan  = is_removal && !empty;
    assign sts.scan_last  = (ptr_reg == scan_end);
    assign sts.shift_done = (ptr_inc >= count_reg);
    assign sts.out_free   = !out_valid_reg || rsp.ready;

    assign commit = cmd.finish && sts.out_free;

    always_comb
    begin
        rd_addr = ptr_reg[pqrl_pkg::IDX_W-1:0];
        if (cmd.scan_start)
        begin
            rd_addr = '0;
        end
        else if (cmd.shift_start)
        begin
            rd_addr = best_idx_reg + pqrl_pkg::IDX_W'(1);
        end
        else if (cmd.shift_step)
        begin
            rd_addr = ptr_inc2[pqrl_pkg::IDX_W-1:0];
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg[pqrl_pkg::IDX_W-1:0];
        wr_id   = rd_id_reg;
        wr_time = rd_time_reg;
        if (cmd.shift_step && !sts.shift_done)
        begin
            wr_en = 1'b1;
        end
        else if (commit && (req_type_reg == pqrl_pkg::REQ_ENQUEUE) && !full)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[pqrl_pkg::IDX_W-1:0];
            wr_id   = id_in_reg;
            wr_time = time_in_reg;
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.scan_start)
        begin
            ptr_next = pqrl_pkg::CNT_W'(1);
        end
        else if (cmd.scan_step)
        begin
            ptr_next = ptr_inc;
        end
        else if (cmd.shift_start)
        begin
            ptr_next = pqrl_pkg::CNT_W'(best_idx_reg);
        end
        else if (cmd.shift_step && !sts.shift_done)
        begin
            ptr_next = ptr_inc;
        end
    end

    always_comb
    begin
        count_next      = count_reg;
        out_status_next = pqrl_pkg::ST_DONE;
        out_id_next     = '0;
        case (req_type_reg)
            pqrl_pkg::REQ_ENQUEUE:
            begin
                if (full)
                begin
                    out_status_next = pqrl_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + pqrl_pkg::CNT_W'(1);
                end
            end
            pqrl_pkg::REQ_DEQUEUE, pqrl_pkg::REQ_REMOVE:
            begin
                if (empty)
                begin
                    out_status_next = pqrl_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next  = count_reg - pqrl_pkg::CNT_W'(1);
                    out_id_next = pqrl_pkg::ID_FIELD_W'(best_id_reg);
                end
            end
            default:
            begin
                out_status_next = pqrl_pkg::ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_status_reg <= out_status_next;
            out_id_reg     <= out_id_next;
            out_count_reg  <= pqrl_pkg::COUNT_FIELD_W'(count_next);
        end
        if (cmd.load)
        begin
            req_type_reg <= req_type;
            id_in_reg    <= pqrl_pkg::ID_BITS'(proc_id);
            time_in_reg  <= pqrl_pkg::TIME_BITS'(run_time);
        end
        ptr_reg <= ptr_next;
        if (cmd.scan_step && take_new)
        begin
            best_idx_reg  <= eval_pos[pqrl_pkg::IDX_W-1:0];
            best_time_reg <= rd_time_reg;
            best_id_reg   <= rd_id_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ids_mem[wr_addr]   <= wr_id;
            times_mem[wr_addr] <= wr_time;
        end
        rd_id_reg   <= ids_mem[rd_addr];
        rd_time_reg <= times_mem[rd_addr];
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.out_id      = out_id_reg;
    assign rsp.entry_count = out_count_reg;

endmodule

>>> hw/rtl/process_queue_remove_longest_top.sv
// Channel  Dir  Payload                          Handshake
// req      in   req_type, proc_id, run_time      valid/ready
// rsp      out  status, out_id, entry_count      valid/ready
//
// Enqueue, unused and failed requests go from accept through CHECK to FINISH,
// which writes the result register. Dequeue scans only the head entry and
// remove-longest all n held, then the shift closes the gap: the single memory read
// port walks the entries one per cycle. rst_n clears the count and the result
// valid; entry storage needs no clearing. A stalled rsp holds the result and the
// next request waits until it can be written.
module process_queue_remove_longest_top (
    input  logic        clk,
    input  logic        rst_n,
    pqrl_req_if.sink    req,
    pqrl_rsp_if.source  rsp
);

    pqrl_pkg::pqrl_cmd_t cmd;
    pqrl_pkg::pqrl_sts_t sts;
    logic                in_ready;

    assign req.ready = in_ready;

    pqrl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pqrl_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_type (req.req_type),
        .proc_id  (req.proc_id),
        .run_time (req.run_time),
        .cmd      (cmd),
        .sts      (sts),
        .rsp      (rsp)
    );

endmodule

>>> tb/pqrl_result_checker.sv
module pqrl_result_checker
    import pqrl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    pqrl_req_if  req,
    pqrl_rsp_if  rsp,
    output int   error_count,
    output int   waiting,
    output int   checked,
    output int   full_seen,
    output int   empty_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [ID_FIELD_W-1:0]    out_id;
        logic [COUNT_FIELD_W-1:0] entry_count;
    } queue_result_t;

    logic [ID_BITS-1:0]   held_ids   [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] held_times [QUEUE_DEPTH];
    int                   held = 0;

    queue_result_t expected_results [$];

    initial
    begin
        error_count = 0;
        waiting     = 0;
        checked     = 0;
        full_seen   = 0;
        empty_seen  = 0;
    end

    function automatic queue_result_t predict_queue_outcome(
        input logic [REQ_W-1:0]        kind,
        input logic [ID_FIELD_W-1:0]   id_in,
        input logic [TIME_FIELD_W-1:0] time_in
    );
        queue_result_t r;
        int            best;
        int            pos;
        r.status = ST_DONE;
        r.out_id = '0;
        case (kind)
            REQ_ENQUEUE:
            begin
                if (held >= QUEUE_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    held_ids[held]   = ID_BITS'(id_in);
                    held_times[held] = TIME_BITS'(time_in);
                    held++;
                end
            end
            REQ_DEQUEUE, REQ_REMOVE:
            begin
                if (held == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    best = 0;
                    if (kind == REQ_REMOVE)
                    begin
                        for (pos = 1; pos < held; pos++)
                        begin
                            if (held_times[pos] > held_times[best])
                                best = pos;
                        end
                    end
                    r.out_id = ID_FIELD_W'(held_ids[best]);
                    // close the gap, keep order
                    for (pos = best; pos + 1 < held; pos++)
                    begin
                        held_ids[pos]   = held_ids[pos + 1];
                        held_times[pos] = held_times[pos + 1];
                    end
                    held--;
                end
            end
            default:
            begin
            end
        endcase
        r.entry_count = COUNT_FIELD_W'(held);
        return r;
    endfunction

    task automatic note_failure(input string what);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] mismatch %0d: %s", $realtime, error_count, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t got;
        queue_result_t want;
        if (!rst_n)
        begin
            held = 0;
            expected_results.delete();
            waiting = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.status      = rsp.status;
                got.out_id      = rsp.out_id;
                got.entry_count = rsp.entry_count;
                if (expected_results.size() == 0)
                begin
                    note_failure($sformatf("unexpected result status %0d id %h count %0d",
                                           got.status, got.out_id, got.entry_count));
                end
                else
                begin
                    want = expected_results.pop_front();
                    checked++;
                    if (want.status == ST_FULL)
                        full_seen++;
                    if (want.status == ST_EMPTY)
                        empty_seen++;
                    if (got.status !== want.status || got.out_id !== want.out_id ||
                        got.entry_count !== want.entry_count)
                        note_failure($sformatf(
                            "expected status %0d id %h count %0d, got status %0d id %h count %0d",
                            want.status, want.out_id, want.entry_count,
                            got.status, got.out_id, got.entry_count));
                end
            end
            if (req.valid && req.ready)
                expected_results.push_back(predict_queue_outcome(req.req_type, req.proc_id,
                                                                 req.run_time));
            waiting = expected_results.size();
        end
    end

endmodule

>>> tb/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import pqrl_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n;

    pqrl_req_if req_ch ();
    pqrl_rsp_if rsp_ch ();

    int  error_count;
    int  waiting;
    int  checked;
    int  full_seen;
    int  empty_seen;
    int  sent;
    int  burst_left;
    int  idle_cycles;
    bit  gaps_on;
    logic req_taken;

    process_queue_remove_longest_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    pqrl_result_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .error_count (error_count),
        .waiting     (waiting),
        .checked     (checked),
        .full_seen   (full_seen),
        .empty_seen  (empty_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_taken <= 1'b0;
        else
            req_taken <= req_ch.valid && req_ch.ready;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no request or result moved for %0d cycles", idle_cycles);
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial
    begin
        int mode;
        int span;
        int tick;
        rsp_ch.ready = 1'b0;
        tick = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= ((tick % 24) >= 18);
                endcase
            end
        end
    end

    task automatic send_request(
        input logic [REQ_W-1:0]        kind,
        input logic [ID_FIELD_W-1:0]   id,
        input logic [TIME_FIELD_W-1:0] rt
    );
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.proc_id  <= id;
        req_ch.run_time <= rt;
        do
            @(negedge clk);
        while (!req_taken);
        sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on)
            begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
    endtask

    initial
    begin
        int                      phase;
        int                      n;
        int                      k;
        int                      style;
        int                      fill_bias;
        int                      roll;
        logic [REQ_W-1:0]        kind;
        logic [TIME_FIELD_W-1:0] rt;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_ENQUEUE;
        req_ch.proc_id  = '0;
        req_ch.run_time = '0;
        idle_cycles     = 0;
        sent            = 0;
        gaps_on         = 1'b1;
        burst_left      = $urandom_range(1, 12);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty queue, unused code
        send_request(REQ_DEQUEUE, 16'h1111, 16'h2222);
        send_request(REQ_REMOVE, 16'h3333, 16'h4444);
        send_request(REQ_UNUSED, 16'hFFFF, 16'hFFFF);

        // fill to the brim with extreme ids and run times, tie on the maximum
        send_request(REQ_ENQUEUE, 16'h0000, 16'h0000);
        send_request(REQ_ENQUEUE, 16'hFFFF, 16'hFFFF);
        send_request(REQ_ENQUEUE, 16'hAAAA, 16'h5555);
        send_request(REQ_ENQUEUE, 16'h5555, 16'hAAAA);
        for (k = 4; k < QUEUE_DEPTH; k++)
            send_request(REQ_ENQUEUE, 16'hF000 | 16'(k),
                         (k == 9) ? 16'hFFFF : 16'(k * 4099));
        send_request(REQ_ENQUEUE, 16'hBEEF, 16'h7777);
        send_request(REQ_UNUSED, 16'h0000, 16'h0000);

        // earliest of the tied longest first, then the later one, then the head
        send_request(REQ_REMOVE, 16'h0000, 16'h0000);
        send_request(REQ_REMOVE, 16'h0000, 16'h0000);
        send_request(REQ_DEQUEUE, 16'h0000, 16'h0000);

        for (phase = 0; phase < 13; phase++)
        begin
            style = $urandom_range(0, 2);
            gaps_on = ($urandom_range(0, 3) != 0);
            case (phase % 3)
                0: fill_bias = 80;
                1: fill_bias = 25;
                default: fill_bias = 50;
            endcase
            for (n = 0; n < 30; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    kind = REQ_UNUSED;
                else if (roll < fill_bias)
                    kind = REQ_ENQUEUE;
                else if ($urandom_range(0, 1) == 0)
                    kind = REQ_DEQUEUE;
                else
                    kind = REQ_REMOVE;
                case (style)
                    0: rt = TIME_FIELD_W'($urandom_range(0, 3));
                    1: rt = TIME_FIELD_W'($urandom());
                    default: rt = ($urandom_range(0, 1) == 0) ? '1 : '0;
                endcase
                send_request(kind, ID_FIELD_W'($urandom()), rt);
            end
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;

        wait (waiting == 0);
        repeat (60) @(posedge clk);

        $display("summary: %0d requests sent, %0d results checked", sent, checked);
        $display("summary: %0d full rejections, %0d empty rejections", full_seen, empty_seen);
        if (error_count == 0 && waiting == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/pqrl_pkg.sv
hw/rtl/pqrl_req_if.sv
hw/rtl/pqrl_rsp_if.sv
hw/rtl/pqrl_ctrl.sv
hw/rtl/pqrl_dpath.sv
hw/rtl/process_queue_remove_longest_top.sv
tb/pqrl_result_checker.sv
tb/testbench.sv
